[rtl/tbp_pkg.sv]
//------------------------------------------------------------------------------
// tbp_pkg
// Shared types, register indexes and multiplier widths of the tilt balance block.
//------------------------------------------------------------------------------
package tbp_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 17;

	localparam logic [CfgIdxW-1:0] REG_PROP_GAIN = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_BLEND_WEIGHT = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_STEP_TIME = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_INV_STEP = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_TILT_CUTOFF = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_DRIVE_LIMIT = 3'd7;

	// Serial multiplier operand widths: signed A times unsigned B.
	localparam int unsigned MulAW = 64;
	localparam int unsigned MulBW = 32;
	localparam int unsigned MulPW = MulAW + MulBW;
	localparam int unsigned MulCntW = 5;

	typedef struct packed {
		logic [7:0]  prop_gain;
		logic [7:0]  integ_gain;
		logic [13:0] deriv_gain;
		logic [16:0] blend_weight;
		logic [16:0] step_time;
		logic [9:0]  inv_step;
		logic [10:0] tilt_cutoff;
		logic [14:0] drive_limit;
	} tbp_cfg_t;

	typedef struct packed {
		logic start;
		logic signed [MulAW-1:0] a;
		logic [MulBW-1:0] b;
	} tbp_mul_req_t;

	typedef struct packed {
		logic done;
		logic signed [MulPW-1:0] p;
	} tbp_mul_rsp_t;

endpackage

[rtl/tbp_serial_mul.sv]
//------------------------------------------------------------------------------
// tbp_serial_mul
// Shift-add multiplier: signed A times unsigned B, one bit of B per cycle.
//------------------------------------------------------------------------------
module tbp_serial_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  tbp_pkg::tbp_mul_req_t req,
	output tbp_pkg::tbp_mul_rsp_t rsp
);
	import tbp_pkg::*;

	logic                    busy_q;
	logic [MulCntW-1:0]      cnt_q;
	logic signed [MulPW-1:0] acc_q;
	logic signed [MulPW-1:0] mcand_q;
	logic [MulBW-1:0]        mplier_q;
	logic                    done_q;

	// One multiplier bit per cycle; multiplicand shifts left as it goes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MulCntW'(MulBW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mcand_q <= MulPW'(req.a);
			mplier_q <= req.b;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p = acc_q;

	ap_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without busy");
	ap_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start |=> busy_q || done_q) else $error("busy lost");
	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done not a pulse");

endmodule

[rtl/tbp_divider.sv]
//------------------------------------------------------------------------------
// tbp_divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
//------------------------------------------------------------------------------
module tbp_divider #(
	parameter int unsigned NumW = 72,
	parameter int unsigned DenW = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [NumW-1:0] num,
	input  logic [DenW-1:0]        den,
	output logic                   done,
	output logic signed [NumW-1:0] quo
);
	localparam int unsigned CntW = $clog2(NumW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	logic [NumW-1:0]   mag_q;
	logic [DenW:0]     rem_q;
	logic [DenW-1:0]   den_q;
	logic              neg_q;
	logic [DenW:0]     trial;
	logic [DenW:0]     shifted;

	assign shifted = {rem_q[DenW-1:0], mag_q[NumW-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(NumW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Magnitude shifts out at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NumW-1];
			mag_q <= num[NumW-1] ? NumW'(-num) : NumW'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[DenW]) begin
				rem_q <= trial;
				mag_q <= {mag_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				mag_q <= {mag_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = neg_q ? -$signed(mag_q) : $signed(mag_q);

	ap_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without busy");
	ap_div_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done not a pulse");
	ap_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider busy at done");

endmodule

[rtl/tilt_balance_pid_controller.sv]
//------------------------------------------------------------------------------
// tilt_balance_pid_controller
// Complementary tilt filter followed by an incremental PID drive update.
//------------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries accel_angle and gyro_rate_raw.
//   Output channel (out_valid/out_stall) carries motor_drive, filtered_angle
//   and tilt_cut, one result request per input request.
//   Gains and limits are to be written through cfg_we/cfg_idx/cfg_data only
//   while idle; the block itself does not enforce this. A sequencer drives
//   one shared bit-serial 64x32 multiplier (thirteen products) and a
//   bit-serial 72-bit divider (two divisions). in_stall is high from
//   acceptance until the result is presented, so a new sample is taken only
//   after the previous result is presented. The result register holds its
//   value while out_valid and out_stall are both high. A new sample may
//   start meanwhile; its result waits until the held one is taken.
//   Reset clears the filter and PID history and loads the register defaults.
//------------------------------------------------------------------------------
module tilt_balance_pid_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [11:0]            accel_angle,
	input  logic signed [15:0]            gyro_rate_raw,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [15:0]            motor_drive,
	output logic signed [15:0]            filtered_angle,
	output logic                          tilt_cut,
	input  logic                          cfg_we,
	input  logic [tbp_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [tbp_pkg::CfgDataW-1:0]  cfg_data
);
	import tbp_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_MUL   = 10'b0000000010,
		ST_WMUL  = 10'b0000000100,
		ST_DIV   = 10'b0000001000,
		ST_WDIV  = 10'b0000010000,
		ST_CALC  = 10'b0000100000,
		ST_DONE  = 10'b0001000000,
		ST_OUT   = 10'b0010000000,
		ST_NEXT  = 10'b0100000000,
		ST_HOLD  = 10'b1000000000
	} state_t;

	tbp_cfg_t cfg_q;
	state_t   state_q;
	logic [3:0] step_q;

	logic signed [11:0] accel_q;
	logic signed [15:0] raw_q;
	logic signed [15:0] last_angle_q;
	logic signed [16:0] last_err_q;
	logic signed [16:0] err_prev_q;
	logic signed [31:0] last_drive_q;
	logic signed [71:0] acc_q;
	logic signed [71:0] quo_q;
	logic signed [31:0] rate_q;
	logic signed [15:0] angle_q;
	logic signed [16:0] e_q;
	logic signed [9:0]  i_q;
	logic signed [9:0]  d_q;
	logic signed [31:0] dd_q;
	logic signed [15:0] res_drive_q;
	logic signed [15:0] res_angle_q;
	logic               res_cut_q;
	logic               out_valid_q;

	tbp_mul_req_t mreq;
	tbp_mul_rsp_t mrsp;
	logic               div_start;
	logic signed [71:0] div_num;
	logic [31:0]        div_den;
	logic               div_done;
	logic signed [71:0] div_quo;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain <= 8'd30;
			cfg_q.integ_gain <= 8'd0;
			cfg_q.deriv_gain <= 14'd350;
			cfg_q.blend_weight <= 17'd62259;
			cfg_q.step_time <= 17'd3277;
			cfg_q.inv_step <= 10'd20;
			cfg_q.tilt_cutoff <= 11'd450;
			cfg_q.drive_limit <= 15'd500;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PROP_GAIN: cfg_q.prop_gain <= cfg_data[7:0];
				REG_INTEG_GAIN: cfg_q.integ_gain <= cfg_data[7:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_data[13:0];
				REG_BLEND_WEIGHT: cfg_q.blend_weight <= cfg_data[16:0];
				REG_STEP_TIME: cfg_q.step_time <= cfg_data[16:0];
				REG_INV_STEP: cfg_q.inv_step <= cfg_data[9:0];
				REG_TILT_CUTOFF: cfg_q.tilt_cutoff <= cfg_data[10:0];
				REG_DRIVE_LIMIT: cfg_q.drive_limit <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	tbp_serial_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	tbp_divider #(.NumW(72), .DenW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	// Sequence steps:
	//  0 raw*94          1 /1000 -> rate
	//  2 rate*dt         3 sum*w          4 accel*(65536-w) (added << 32)
	//  5 angle/error     6 dd*inv -> d    7 last_drive*65536000
	//  8 p*kp            9 *6553600      10 ki*i  11 *dt  12 *100
	// 13 kd*d  14 *65536  15 divide by 65536000 and finish
	logic signed [17:0] ew;
	logic [11:0]        accel_mag;
	logic signed [17:0] s_sum;
	logic signed [16:0] p_val;
	logic signed [63:0] ma;
	logic [31:0]        mb;
	logic signed [71:0] sum_tmp;
	logic signed [71:0] ang_full;
	logic signed [15:0] ang_sat;
	logic signed [16:0] ang_neg;
	logic signed [17:0] s_half;
	logic signed [9:0]  i_clamp;
	logic signed [31:0] dd_full;
	logic signed [31:0] drv32;
	logic signed [16:0] lim_s;
	logic signed [16:0] drv_cl;
	logic [15:0]        mag;

	// Accel weight can reach 65536 (w = 0) or go negative (w above 65536)
	assign ew = 18'sd65536 - $signed({1'b0, cfg_q.blend_weight});
	// Accel weight product runs sign-magnitude: weight carries the sign
	assign accel_mag = accel_q[11] ? 12'(-13'(accel_q)) : 12'(accel_q);

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (step_q)
			4'd0: begin ma = 64'(raw_q); mb = 32'd94; end
			4'd2: begin ma = 64'(rate_q); mb = 32'(cfg_q.step_time); end
			4'd3: begin ma = acc_q[63:0]; mb = 32'(cfg_q.blend_weight); end
			4'd4: begin
				ma = accel_q[11] ? 64'(-ew) : 64'(ew);
				mb = 32'(accel_mag);
			end
			4'd6: begin ma = 64'(dd_q); mb = 32'(cfg_q.inv_step); end
			4'd7: begin ma = 64'(last_drive_q); mb = 32'd65536000; end
			4'd8: begin ma = 64'(p_val); mb = 32'(cfg_q.prop_gain); end
			4'd9: begin ma = acc_q[63:0]; mb = 32'd6553600; end
			4'd10: begin ma = 64'(i_q); mb = 32'(cfg_q.integ_gain); end
			4'd11: begin ma = acc_q[63:0]; mb = 32'(cfg_q.step_time); end
			4'd12: begin ma = acc_q[63:0]; mb = 32'd100; end
			4'd13: begin ma = 64'(d_q); mb = 32'(cfg_q.deriv_gain); end
			4'd14: begin ma = acc_q[63:0]; mb = 32'd65536; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign p_val = e_q - last_err_q;
	assign mreq.start = (state_q == ST_MUL);
	assign mreq.a = ma;
	assign mreq.b = mb;

	// Divider is used for /1000 and /65536000
	assign div_start = (state_q == ST_DIV);
	assign div_num = quo_q;
	assign div_den = (step_q == 4'd1) ? 32'd1000 : 32'd65536000;

	// Angle saturation and error terms from the Q32 blend
	assign ang_full = acc_q >>> 32;
	assign ang_sat = (acc_q < 0 && acc_q[31:0] != 0) ?
		((ang_full + 72'sd1 > 72'sd32767) ? 16'sd32767 :
		 (ang_full + 72'sd1 < -72'sd32768) ? -16'sd32768 : 16'(ang_full + 72'sd1)) :
		((ang_full > 72'sd32767) ? 16'sd32767 :
		 (ang_full < -72'sd32768) ? -16'sd32768 : 16'(ang_full));
	assign ang_neg = -17'(ang_sat);
	assign s_sum = 18'(ang_neg) + 18'(last_err_q);
	assign s_half = s_sum >>> 1;
	assign i_clamp = (s_half > 18'sd300) ? 10'sd300 :
		(s_half < -18'sd300) ? -10'sd300 : 10'(s_half);
	assign dd_full = 32'(ang_neg) - (32'(last_err_q) <<< 1) + 32'(err_prev_q);

	// Drive saturation and clamp
	assign drv32 = (quo_q > 72'sd2147483647) ? 32'h7fffffff :
		(quo_q < -72'sd2147483648) ? 32'h80000000 : 32'(quo_q);
	assign lim_s = $signed({2'b0, cfg_q.drive_limit});
	assign drv_cl = (drv32 > 32'(lim_s)) ? lim_s :
		(drv32 < -32'(lim_s)) ? -lim_s : 17'(drv32);
	assign mag = angle_q[15] ? 16'(-angle_q) : 16'(angle_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
			last_angle_q <= '0;
			last_err_q <= '0;
			err_prev_q <= '0;
			last_drive_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_MUL;
					step_q <= '0;
				end
				ST_MUL: state_q <= ST_WMUL;
				ST_WMUL: if (mrsp.done) state_q <= ST_CALC;
				ST_DIV: state_q <= ST_WDIV;
				ST_WDIV: if (div_done) state_q <= ST_CALC;
				ST_CALC: begin
					step_q <= step_q + 1'b1;
					unique case (step_q) inside
						4'd0, 4'd14: state_q <= ST_DIV;
						4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
						4'd10, 4'd11, 4'd12, 4'd13: state_q <= ST_MUL;
						4'd4: state_q <= ST_NEXT;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_NEXT: begin
					state_q <= ST_MUL;
					step_q <= step_q + 1'b1;
				end
				ST_DONE: begin
					err_prev_q <= last_err_q;
					last_err_q <= e_q;
					last_angle_q <= angle_q;
					if (mag > 16'(cfg_q.tilt_cutoff)) last_drive_q <= drv32;
					else last_drive_q <= 32'(drv_cl);
					state_q <= ST_HOLD;
				end
				ST_HOLD: if (!out_valid_q || !out_stall) state_q <= ST_OUT;
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				accel_q <= accel_angle;
				raw_q <= gyro_rate_raw;
			end
			ST_WDIV: if (div_done) quo_q <= div_quo;
			ST_WMUL: if (mrsp.done) quo_q <= 72'(mrsp.p);
			ST_CALC: begin
				case (step_q) inside
					4'd0: begin
						acc_q <= '0;
					end
					4'd1: rate_q <= 32'(quo_q);
					4'd2: acc_q <= quo_q + (72'(last_angle_q) <<< 16);
					4'd3: acc_q <= quo_q;
					4'd4: acc_q <= acc_q + (quo_q <<< 32);
					4'd6: begin
						d_q <= (quo_q > 72'sd300) ? 10'sd300 :
							(quo_q < -72'sd300) ? -10'sd300 : 10'(quo_q);
						sum_tmp <= '0;
					end
					4'd7: sum_tmp <= quo_q;
					4'd8: acc_q <= quo_q;
					4'd9: sum_tmp <= sum_tmp + quo_q;
					4'd10, 4'd11, 4'd13: acc_q <= quo_q;
					4'd12: sum_tmp <= sum_tmp + quo_q;
					4'd14: begin
						sum_tmp <= sum_tmp + quo_q;
						quo_q <= sum_tmp + quo_q;
					end
					default: ;
				endcase
			end
			ST_NEXT: begin
				angle_q <= ang_sat;
				e_q <= ang_neg;
				i_q <= i_clamp;
				dd_q <= dd_full;
			end
			// Result register loads only once the held result is gone
			ST_HOLD: if (!out_valid_q || !out_stall) begin
				res_angle_q <= angle_q;
				if (mag > 16'(cfg_q.tilt_cutoff)) begin
					res_drive_q <= '0;
					res_cut_q <= 1'b1;
				end else begin
					res_drive_q <= 16'(drv_cl);
					res_cut_q <= 1'b0;
				end
			end
			default: ;
		endcase
		if (state_q == ST_CALC && step_q == 4'd0) quo_q <= quo_q;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign motor_drive = res_drive_q;
	assign filtered_angle = res_angle_q;
	assign tilt_cut = res_cut_q;

	ap_one_hot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	ap_out_after_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result without sequence");
	ap_cut_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_cut_q |-> res_drive_q == 16'sd0)
		else $error("drive not zero at cutoff");

endmodule
